// ----- sv/deq_pkg.sv -----
// Package: command and status codes, beat types and row control for the deque core.
package deq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int OCC_W         = 5;

    typedef enum logic [2:0] {
        CMD_SIZE       = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_PUSH_FRONT = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_POP_FRONT  = 3'd4,
        CMD_FRONT      = 3'd5,
        CMD_BACK       = 3'd6,
        CMD_CLEAR      = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_VALUE     = 2'd1,
        ST_ERR_EMPTY = 2'd2,
        ST_ERR_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                      cmd;
        logic signed [WORD_W-1:0]  push_word;
    } t_in_beat;

    typedef struct packed {
        t_status                   status;
        logic signed [WORD_W-1:0]  result_word;
        logic [OCC_W-1:0]          occupancy;
    } t_out_beat;

    // shift_r: insert at cell 0, shift_l: drop cell 0, load: write cell at count
    typedef struct packed {
        logic shift_r;
        logic shift_l;
        logic load;
    } t_row_ctl;

endpackage

// ----- sv/deq_cell.sv -----
// One storage cell of a deque row: holds a word, takes from either neighbor or the push bus.
module deq_cell
    import deq_pkg::*;
#(
    parameter int CW    = 5,
    parameter int INDEX = 0
) (
    input  logic                     i_clk,
    input  t_row_ctl                 i_ctl,
    input  logic [CW-1:0]            i_count,
    input  logic signed [WORD_W-1:0] i_push_word,
    input  logic signed [WORD_W-1:0] i_left_word,
    input  logic signed [WORD_W-1:0] i_right_word,
    output logic signed [WORD_W-1:0] o_word
);

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.shift_r) begin
            n_word = i_left_word;
        end else if (i_ctl.shift_l) begin
            n_word = i_right_word;
        end else if (i_ctl.load && (i_count == CW'(INDEX))) begin
            n_word = i_push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

// ----- sv/deq_row.sv -----
// Row of deque cells with its head at cell 0; words move one cell per shift.
module deq_row
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  t_row_ctl                 i_ctl,
    input  logic [CW-1:0]            i_count,
    input  logic signed [WORD_W-1:0] i_push_word,
    output logic signed [WORD_W-1:0] o_head_word
);

    logic signed [WORD_W-1:0] w_word [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [WORD_W-1:0] w_left;
        logic signed [WORD_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = i_push_word;
        end else begin : g_mid_l
            assign w_left = w_word[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_word[g];
        end else begin : g_mid_r
            assign w_right = w_word[g+1];
        end

        deq_cell #(
            .CW    (CW),
            .INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_count      (i_count),
            .i_push_word  (i_push_word),
            .i_left_word  (w_left),
            .i_right_word (w_right),
            .o_word       (w_word[g])
        );
    end

    assign o_head_word = w_word[0];

endmodule

// ----- sv/double_ended_queue_core.sv -----
// Top level of the double-ended queue core: command decode, fill count and result register.
//
// Every command beat is taken as it is presented and its result beat appears on o_result with
// o_done high in the next cycle; o_busy stays low, so a command may be issued every
// cycle. Results cannot be stalled. The queue is held in two rows of DEPTH cells, one with
// the front word at its head and one with the back word at its head; pushes shift one row
// by a cell and write the other row at the cell that the fill count selects, pops shift
// only one row, so both ends are always read at a fixed cell.
module double_ended_queue_core
    import deq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_beat  i_item,
    output logic      o_busy,
    output logic      o_done,
    output t_out_beat o_result
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_done;
    t_out_beat                r_result;
    t_out_beat                n_result;
    t_row_ctl                 w_front_ctl;
    t_row_ctl                 w_back_ctl;
    logic signed [WORD_W-1:0] w_front_word;
    logic signed [WORD_W-1:0] w_back_word;
    logic                     w_accept;
    logic                     w_empty;
    logic                     w_full;
    logic [31:0]              w_count_ext;
    logic [31:0]              w_next_ext;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_empty  = (r_count == '0);
    assign w_full   = (r_count == CW'(DEPTH));

    assign w_count_ext = 32'(r_count);
    assign w_next_ext  = 32'(n_count);

    always_comb begin
        n_count     = r_count;
        w_front_ctl = '0;
        w_back_ctl  = '0;
        n_result.status      = ST_OK;
        n_result.result_word = '0;
        case (i_item.cmd)
            CMD_SIZE: begin
                n_result.status      = ST_VALUE;
                n_result.result_word = w_count_ext;
            end
            CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_result.status = ST_ERR_FULL;
                end else begin
                    w_front_ctl.load  = w_accept;
                    w_back_ctl.shift_r = w_accept;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_PUSH_FRONT: begin
                if (w_full) begin
                    n_result.status = ST_ERR_FULL;
                end else begin
                    w_front_ctl.shift_r = w_accept;
                    w_back_ctl.load     = w_accept;
                    n_count = r_count + CW'(1);
                end
            end
            CMD_POP_BACK: begin
                if (w_empty) begin
                    n_result.status = ST_ERR_EMPTY;
                end else begin
                    w_back_ctl.shift_l   = w_accept;
                    n_result.status      = ST_VALUE;
                    n_result.result_word = w_back_word;
                    n_count = r_count - CW'(1);
                end
            end
            CMD_POP_FRONT: begin
                if (w_empty) begin
                    n_result.status = ST_ERR_EMPTY;
                end else begin
                    w_front_ctl.shift_l  = w_accept;
                    n_result.status      = ST_VALUE;
                    n_result.result_word = w_front_word;
                    n_count = r_count - CW'(1);
                end
            end
            CMD_FRONT: begin
                if (w_empty) begin
                    n_result.status = ST_ERR_EMPTY;
                end else begin
                    n_result.status      = ST_VALUE;
                    n_result.result_word = w_front_word;
                end
            end
            CMD_BACK: begin
                if (w_empty) begin
                    n_result.status = ST_ERR_EMPTY;
                end else begin
                    n_result.status      = ST_VALUE;
                    n_result.result_word = w_back_word;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_result.occupancy = w_next_ext[OCC_W-1:0];
    end

    deq_row #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_front_row (
        .i_clk       (i_clk),
        .i_ctl       (w_front_ctl),
        .i_count     (r_count),
        .i_push_word (i_item.push_word),
        .o_head_word (w_front_word)
    );

    deq_row #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_back_row (
        .i_clk       (i_clk),
        .i_ctl       (w_back_ctl),
        .i_count     (r_count),
        .i_push_word (i_item.push_word),
        .o_head_word (w_back_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the double-ended queue core: directed and random command beats.
module testbench
    import deq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH         = DEPTH_DEFAULT;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int RANDOM_BLOCKS  = 12;
    localparam int BLOCK_BEATS    = 50;

    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_mix;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    t_in_beat  i_item;
    logic      o_busy;
    logic      o_done;
    t_out_beat o_result;

    double_ended_queue_core #(
        .DEPTH(QDEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_item  (i_item),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // predictor state
    logic signed [WORD_W-1:0] ring_mem [QDEPTH];
    int head_idx;
    int tail_idx;
    int word_count;

    t_out_beat pending_results [$];
    t_out_beat want_beat;
    int        fail_count;
    int        idle_cycles;
    bit        gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_beat deque_step(t_in_beat b);
        t_out_beat r;
        bit        is_empty;
        bit        is_full;
        is_empty      = (word_count == 0);
        is_full       = (word_count >= QDEPTH);
        r.status      = ST_OK;
        r.result_word = '0;
        case (b.cmd)
            CMD_SIZE: begin
                r.status      = ST_VALUE;
                r.result_word = WORD_W'(word_count);
            end
            CMD_PUSH_BACK: begin
                if (is_full) begin
                    r.status = ST_ERR_FULL;
                end else begin
                    ring_mem[tail_idx] = b.push_word;
                    tail_idx           = (tail_idx + 1) % QDEPTH;
                    word_count++;
                end
            end
            CMD_PUSH_FRONT: begin
                if (is_full) begin
                    r.status = ST_ERR_FULL;
                end else begin
                    head_idx           = (head_idx + QDEPTH - 1) % QDEPTH;
                    ring_mem[head_idx] = b.push_word;
                    word_count++;
                end
            end
            CMD_POP_BACK: begin
                if (is_empty) begin
                    r.status = ST_ERR_EMPTY;
                end else begin
                    tail_idx      = (tail_idx + QDEPTH - 1) % QDEPTH;
                    r.result_word = ring_mem[tail_idx];
                    r.status      = ST_VALUE;
                    word_count--;
                end
            end
            CMD_POP_FRONT: begin
                if (is_empty) begin
                    r.status = ST_ERR_EMPTY;
                end else begin
                    r.result_word = ring_mem[head_idx];
                    head_idx      = (head_idx + 1) % QDEPTH;
                    r.status      = ST_VALUE;
                    word_count--;
                end
            end
            CMD_FRONT: begin
                if (is_empty) begin
                    r.status = ST_ERR_EMPTY;
                end else begin
                    r.result_word = ring_mem[head_idx];
                    r.status      = ST_VALUE;
                end
            end
            CMD_BACK: begin
                if (is_empty) begin
                    r.status = ST_ERR_EMPTY;
                end else begin
                    r.result_word = ring_mem[(tail_idx + QDEPTH - 1) % QDEPTH];
                    r.status      = ST_VALUE;
                end
            end
            default: begin
                head_idx   = 0;
                tail_idx   = 0;
                word_count = 0;
            end
        endcase
        r.occupancy = OCC_W'(word_count);
        return r;
    endfunction

    // result checker, predictor and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %p",
                             $time, o_result);
                    fail_count++;
                end else begin
                    want_beat = pending_results[0];
                    pending_results.delete(0);
                    if (o_result.status !== want_beat.status) begin
                        $display("%0t: status mismatch, expected %s actual %0d", $time,
                                 want_beat.status.name(), o_result.status);
                        fail_count++;
                    end
                    if (o_result.result_word !== want_beat.result_word) begin
                        $display("%0t: result_word mismatch, expected %0d actual %0d",
                                 $time, want_beat.result_word, o_result.result_word);
                        fail_count++;
                    end
                    if (o_result.occupancy !== want_beat.occupancy) begin
                        $display("%0t: occupancy mismatch, expected %0d actual %0d",
                                 $time, want_beat.occupancy, o_result.occupancy);
                        fail_count++;
                    end
                end
            end
            if (i_start && !o_busy) begin
                pending_results.insert(pending_results.size(), deque_step(i_item));
            end
            if (o_done || (i_start && !o_busy)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic send_beat(input t_cmd c, input logic signed [WORD_W-1:0] w);
        int gap;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_item  <= '{cmd: c, push_word: w};
        do begin
            @(posedge i_clk);
        end while (o_busy);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_cmd pick_cmd(input t_mix mix);
        int r;
        int push_pct;
        int pop_pct;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   begin push_pct = 65; pop_pct = 20; end
            MIX_SHRINK: begin push_pct = 25; pop_pct = 60; end
            default:    begin push_pct = 45; pop_pct = 40; end
        endcase
        if (r < push_pct)
            return (r % 2) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        if (r < push_pct + pop_pct)
            return (r % 2) ? CMD_POP_BACK : CMD_POP_FRONT;
        case (r % 8)
            0, 1:    return CMD_FRONT;
            2, 3:    return CMD_BACK;
            4, 5, 6: return CMD_SIZE;
            default: return ($urandom_range(0, 2) == 0) ? CMD_CLEAR : CMD_SIZE;
        endcase
    endfunction

    task automatic test_empty_errors();
        send_beat(CMD_SIZE, '0);
        send_beat(CMD_POP_BACK, '1);
        send_beat(CMD_POP_FRONT, '0);
        send_beat(CMD_FRONT, '0);
        send_beat(CMD_BACK, '0);
    endtask

    task automatic test_fill_to_full();
        send_beat(CMD_PUSH_BACK, 32'sh7fff_ffff);
        send_beat(CMD_PUSH_FRONT, 32'sh8000_0000);
        send_beat(CMD_PUSH_BACK, '1);
        send_beat(CMD_PUSH_FRONT, '0);
        for (int k = 4; k < QDEPTH; k++) begin
            send_beat((k % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
        end
        send_beat(CMD_PUSH_BACK, 32'sh1234_5678);
        send_beat(CMD_PUSH_FRONT, 32'sh5555_aaaa);
        send_beat(CMD_SIZE, '0);
        send_beat(CMD_FRONT, '0);
        send_beat(CMD_BACK, '0);
    endtask

    task automatic test_clear();
        send_beat(CMD_CLEAR, '1);
        send_beat(CMD_SIZE, '0);
        send_beat(CMD_POP_FRONT, '0);
    endtask

    task automatic test_random_mix();
        t_mix mix;
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            mix     = t_mix'($urandom_range(0, 2));
            gaps_on = ($urandom_range(0, 2) != 0);
            for (int k = 0; k < BLOCK_BEATS; k++) begin
                send_beat(pick_cmd(mix), pick_word());
            end
            if (blk == RANDOM_BLOCKS / 2)
                wait_drained();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_item      = '0;
        fail_count  = 0;
        idle_cycles = 0;
        gaps_on     = 1'b1;
        head_idx    = 0;
        tail_idx    = 0;
        word_count  = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_errors();
        test_fill_to_full();
        test_clear();
        test_random_mix();

        wait_drained();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
